// ===== sv/ubx_frame_receiver_core_macros.svh =====
// ----------------------------------------------------------------------------
// ubx frame receiver assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_RECEIVER_CORE_MACROS_SVH
`define UBX_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define UBX_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ubx frame receiver check failed");

// next-cycle implication
`define UBX_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ubx frame receiver check failed");

`endif

// ===== sv/ubx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_pkg
// shared types, constants and codes of the ubx frame receiver
// ----------------------------------------------------------------------------
package ubx_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = 9;
    localparam int LIMIT_W     = 10;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [7:0]         SYNC_FIRST_RST   = 8'hB5;
    localparam logic [7:0]         SYNC_SECOND_RST  = 8'h62;
    localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = LIMIT_W'(512);

    // register indexes
    localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    // status codes
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_REJECT     = 2'd1;
    localparam logic [1:0] ST_VALID      = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;

    // frame phases
    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN1    = 4'd4;
    localparam logic [3:0] PH_LEN2    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK1     = 4'd7;
    localparam logic [3:0] PH_CK2     = 4'd8;

    typedef struct packed {
        logic [7:0]         sync_first;
        logic [7:0]         sync_second;
        logic [LIMIT_W-1:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       error_kind;
        logic             payload_valid;
        logic [IDX_W-1:0] payload_index;
        logic [7:0]       payload_byte;
        logic [7:0]       message_class;
        logic [7:0]       message_id;
        logic [15:0]      message_length;
        logic [31:0]      frames_received;
        logic [31:0]      overflow_count;
        logic [31:0]      checksum_error_count;
    } result_t;

endpackage

// ===== sv/ubx_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_receiver_core
// ubx binary frame deframer with running fletcher-8 checksum
// ----------------------------------------------------------------------------
// Takes one serial byte per request and returns one result per byte. The
// block sustains one byte per clock while out_stall does not hold the output
// register: a byte sits in the input register, the frame state and checksum
// are updated from it, and the result lands in the output register. The input
// register can take a new byte while its previous byte moves on to the output
// register. Configure sync bytes and length limit over apb only while no byte
// is in flight.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ubx_pkg::ADDR_W-1:0] paddr,
    input  logic [ubx_pkg::DATA_W-1:0] pwdata,
    output logic [ubx_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [1:0]                 error_kind,
    output logic                       payload_valid,
    output logic [8:0]                 payload_index,
    output logic [7:0]                 payload_byte,
    output logic [7:0]                 message_class,
    output logic [7:0]                 message_id,
    output logic [15:0]                message_length,
    output logic [31:0]                frames_received,
    output logic [31:0]                overflow_count,
    output logic [31:0]                checksum_error_count
);
    import ubx_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       out_free;
    logic       advance;
    logic       accept;

    ubx_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ubx_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
        if (advance)
            out_reg <= result;
    end

    assign out_valid            = out_valid_reg;
    assign status               = out_reg.status;
    assign error_kind           = out_reg.error_kind;
    assign payload_valid        = out_reg.payload_valid;
    assign payload_index        = out_reg.payload_index;
    assign payload_byte         = out_reg.payload_byte;
    assign message_class        = out_reg.message_class;
    assign message_id           = out_reg.message_id;
    assign message_length       = out_reg.message_length;
    assign frames_received      = out_reg.frames_received;
    assign overflow_count       = out_reg.overflow_count;
    assign checksum_error_count = out_reg.checksum_error_count;

endmodule

// ===== sv/ubx_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_cfg_regs
// apb register file for sync bytes and payload length limit
// ----------------------------------------------------------------------------
module ubx_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ubx_pkg::ADDR_W-1:0] paddr,
    input  logic [ubx_pkg::DATA_W-1:0] pwdata,
    output logic [ubx_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ubx_pkg::cfg_t              cfg
);
    import ubx_pkg::*;

    logic [7:0]         sync_first_reg;
    logic [7:0]         sync_second_reg;
    logic [LIMIT_W-1:0] length_limit_reg;
    logic               wr_en;
    logic [1:0]         reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg   <= SYNC_FIRST_RST;
            sync_second_reg  <= SYNC_SECOND_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_SYNC_FIRST:   sync_first_reg   <= pwdata[7:0];
                REG_SYNC_SECOND:  sync_second_reg  <= pwdata[7:0];
                REG_LENGTH_LIMIT: length_limit_reg <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SYNC_FIRST:   prdata = DATA_W'(sync_first_reg);
            REG_SYNC_SECOND:  prdata = DATA_W'(sync_second_reg);
            REG_LENGTH_LIMIT: prdata = DATA_W'(length_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.sync_first   = sync_first_reg;
    assign cfg.sync_second  = sync_second_reg;
    assign cfg.length_limit = length_limit_reg;

endmodule

// ===== sv/ubx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_parser
// frame state, running fletcher-8 checksum and counters, one byte per cycle while advance is high
// ----------------------------------------------------------------------------
module ubx_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       byte_in,
    input  ubx_pkg::cfg_t    cfg,
    output ubx_pkg::result_t result
);
    import ubx_pkg::*;

    logic [3:0]       phase_reg,     phase_next;
    logic [7:0]       class_reg,     class_next;
    logic [7:0]       id_reg,        id_next;
    logic [15:0]      length_reg,    length_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [7:0]       sum_a_reg,     sum_a_next;
    logic [7:0]       sum_b_reg,     sum_b_next;
    logic [7:0]       rsum_a_reg,    rsum_a_next;
    logic [31:0]      good_reg,      good_next;
    logic [31:0]      ovf_reg,       ovf_next;
    logic [31:0]      ckerr_reg,     ckerr_next;

    logic [7:0]       add_a;
    logic [7:0]       add_b;
    logic [7:0]       init_a;
    logic [15:0]      limit;
    logic [15:0]      len_full;
    logic [CNT_W-1:0] count_inc;
    logic [1:0]       status;
    logic [1:0]       error_kind;
    logic             pv;

    assign add_a     = sum_a_reg + byte_in;
    assign add_b     = sum_b_reg + add_a;
    assign init_a    = byte_in;
    assign len_full  = {byte_in, length_reg[7:0]};
    assign count_inc = count_reg + CNT_W'(1);
    assign limit     = (16'(cfg.length_limit) > 16'(MAX_PAYLOAD)) ?
                       16'(MAX_PAYLOAD) : 16'(cfg.length_limit);

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        rsum_a_next = rsum_a_reg;
        good_next   = good_reg;
        ovf_next    = ovf_reg;
        ckerr_next  = ckerr_reg;
        status      = ST_INCOMPLETE;
        error_kind  = ERR_NONE;
        pv          = 1'b0;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (byte_in == cfg.sync_first)
                    phase_next = PH_SYNC2;
                else
                    status = ST_REJECT;
            end
            PH_SYNC2:
            begin
                if (byte_in == cfg.sync_second)
                    phase_next = PH_CLASS;
                else
                begin
                    phase_next = PH_SYNC1;
                    status     = ST_REJECT;
                end
            end
            PH_CLASS:
            begin
                class_next = byte_in;
                sum_a_next = init_a;
                sum_b_next = init_a;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = byte_in;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                length_next = {8'h00, byte_in};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = PH_LEN2;
            end
            PH_LEN2:
            begin
                length_next = len_full;
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                count_next  = '0;
                if (len_full > limit)
                begin
                    ovf_next   = ovf_reg + 32'd1;
                    status     = ST_REJECT;
                    error_kind = ERR_OVERFLOW;
                    phase_next = PH_SYNC1;
                end
                else if (len_full == 16'd0)
                    phase_next = PH_CK1;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                pv         = 1'b1;
                count_next = count_inc;
                if (16'(count_inc) >= length_reg)
                    phase_next = PH_CK1;
            end
            PH_CK1:
            begin
                rsum_a_next = byte_in;
                phase_next  = PH_CK2;
            end
            PH_CK2:
            begin
                if (rsum_a_reg == sum_a_reg && byte_in == sum_b_reg)
                begin
                    good_next = good_reg + 32'd1;
                    status    = ST_VALID;
                end
                else
                begin
                    ckerr_next = ckerr_reg + 32'd1;
                    status     = ST_REJECT;
                    error_kind = ERR_CHECKSUM;
                end
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                status     = ST_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            class_reg  <= '0;
            id_reg     <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            rsum_a_reg <= '0;
            good_reg   <= '0;
            ovf_reg    <= '0;
            ckerr_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            rsum_a_reg <= rsum_a_next;
            good_reg   <= good_next;
            ovf_reg    <= ovf_next;
            ckerr_reg  <= ckerr_next;
        end
    end

    assign result.status               = status;
    assign result.error_kind           = error_kind;
    assign result.payload_valid        = pv;
    assign result.payload_index        = pv ? IDX_W'(count_reg) : '0;
    assign result.payload_byte         = pv ? byte_in : 8'h00;
    assign result.message_class        = class_next;
    assign result.message_id           = id_next;
    assign result.message_length       = length_next;
    assign result.frames_received      = good_next;
    assign result.overflow_count       = ovf_next;
    assign result.checksum_error_count = ckerr_next;

endmodule

// ===== sv/ubx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_checker
// port-level checks of the ubx frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "ubx_frame_receiver_core_macros.svh"

module ubx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [1:0]  error_kind,
    input logic        payload_valid,
    input logic [31:0] frames_received
);
    import ubx_pkg::*;

    `UBX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `UBX_ASSERT_NEXT(a_count_hold, clk, rst_n, out_valid && out_stall, $stable(frames_received))
    `UBX_ASSERT_SAME(a_err_rejects, clk, rst_n, out_valid && error_kind != ERR_NONE, status == ST_REJECT)
    `UBX_ASSERT_SAME(a_payload_plain, clk, rst_n, out_valid && payload_valid, status == ST_INCOMPLETE && error_kind == ERR_NONE)

endmodule

bind ubx_frame_receiver_core ubx_checker u_ubx_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .error_kind      (error_kind),
    .payload_valid   (payload_valid),
    .frames_received (frames_received)
);
